@@ src/mi_pkg.sv @@
// Shared types and constants for the modular inverse block.
// Used by mi_euclid and modular_inverse; depends on nothing else.
`default_nettype none

package mi_pkg;

  localparam int WIDTH   = 32;
  localparam int SHIFT_W = $clog2(WIDTH);

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOINV  = 2'd1;
  localparam logic [1:0] STAT_BADMOD = 2'd2;

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;
  } req_t;

  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic [1:0]       status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_FIX,
    ST_NEG,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

@@ src/mi_euclid.sv @@
// Extended Euclidean sequencer built around one shared subtractor.
// Division steps are done by shift and subtract; depends on mi_pkg.
`default_nettype none

module mi_euclid (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire mi_pkg::req_t req,
  input  wire logic         take,
  output logic              idle,
  output logic              done,
  output mi_pkg::rsp_t      rsp
);
  import mi_pkg::*;

  state_t state, state_next;

  logic [WIDTH-1:0]   rp, rp_next;
  logic [WIDTH-1:0]   rc, rc_next;
  logic [WIDTH-1:0]   up, up_next;
  logic [WIDTH-1:0]   uc, uc_next;
  logic [WIDTH-1:0]   m, m_next;
  logic [SHIFT_W-1:0] s, s_next;
  logic               pos, pos_next;
  logic [WIDTH-1:0]   inv, inv_next;
  logic [1:0]         st, st_next;

  logic [WIDTH+1:0] sub_a, sub_b, diff;
  logic             ge;
  logic [WIDTH-1:0] rem, unew;

  // The one subtractor; its operands depend on the current step.
  always_comb begin
    unique case (state)
      ST_ALIGN: begin
        sub_a = {2'b00, rp};
        sub_b = {1'b0, rc, 1'b0};
      end
      ST_FIX: begin
        sub_a = {2'b00, up};
        sub_b = {2'b00, m};
      end
      ST_NEG: begin
        sub_a = {2'b00, m};
        sub_b = {2'b00, up};
      end
      default: begin
        sub_a = {2'b00, rp};
        sub_b = {2'b00, rc};
      end
    endcase
  end

  assign diff = sub_a - sub_b;
  assign ge   = !diff[WIDTH+1];
  assign rem  = ge ? diff[WIDTH-1:0] : rp;
  assign unew = ge ? up + uc : up;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (req.modulus == '0 || req.modulus == WIDTH'(1)) begin
            state_next = ST_RESULT;
          end else begin
            state_next = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        if (!ge) begin
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        if (s == '0) begin
          if (rem == '0) begin
            state_next = (rc == WIDTH'(1)) ? ST_FIX : ST_RESULT;
          end else begin
            state_next = ST_ALIGN;
          end
        end
      end
      ST_FIX: state_next = ST_NEG;
      ST_NEG: state_next = ST_RESULT;
      ST_RESULT: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rp_next  = rp;
    rc_next  = rc;
    up_next  = up;
    uc_next  = uc;
    m_next   = m;
    s_next   = s;
    pos_next = pos;
    inv_next = inv;
    st_next  = st;
    unique case (state)
      ST_IDLE: begin
        rp_next  = req.value;
        rc_next  = req.modulus;
        up_next  = WIDTH'(1);
        uc_next  = '0;
        m_next   = req.modulus;
        s_next   = '0;
        pos_next = 1'b0;
        inv_next = '0;
        st_next  = (req.modulus == '0) ? STAT_BADMOD : STAT_OK;
      end
      ST_ALIGN: begin
        if (ge) begin
          rc_next = {rc[WIDTH-2:0], 1'b0};
          uc_next = {uc[WIDTH-2:0], 1'b0};
          s_next  = s + SHIFT_W'(1);
        end
      end
      ST_SUB: begin
        if (s == '0) begin
          rp_next  = rc;
          rc_next  = rem;
          up_next  = uc;
          uc_next  = unew;
          pos_next = !pos;
          if (rem == '0 && rc != WIDTH'(1)) begin
            inv_next = '0;
            st_next  = STAT_NOINV;
          end
        end else begin
          rp_next = rem;
          up_next = unew;
          rc_next = {1'b0, rc[WIDTH-1:1]};
          uc_next = {1'b0, uc[WIDTH-1:1]};
          s_next  = s - SHIFT_W'(1);
        end
      end
      ST_FIX: begin
        if (ge) begin
          up_next = diff[WIDTH-1:0];
        end
      end
      ST_NEG: begin
        st_next = STAT_OK;
        if (!pos) begin
          inv_next = up;
        end else begin
          inv_next = (up == '0) ? '0 : diff[WIDTH-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idle        = (state == ST_IDLE);
    done        = (state == ST_RESULT);
    rsp.inverse = inv;
    rsp.status  = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rp  <= rp_next;
    rc  <= rc_next;
    up  <= up_next;
    uc  <= uc_next;
    m   <= m_next;
    s   <= s_next;
    pos <= pos_next;
    inv <= inv_next;
    st  <= st_next;
  end

endmodule

`default_nettype wire

@@ src/modular_inverse.sv @@
// Top level of the modular inverse block: request and response channels.
// Instantiates mi_euclid; depends on mi_pkg.
//
//   channel   direction   payload        handshake
//   req       in          mi_pkg::req_t  req_valid / req_stall
//   rsp       out         mi_pkg::rsp_t  rsp_valid / rsp_stall
//
// One request is worked on at a time; req_stall stays high until it is done.
// Each Euclidean division step shifts the divisor up into alignment, compares,
// then develops the quotient bits by shift and subtract. Setup, the final
// correction and the result state come on top of the division steps.
// The response sits in an output register, so a stall on rsp only holds the
// finished result. Reset is synchronous and clears the control state.
`default_nettype none

module modular_inverse (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire mi_pkg::req_t req,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output mi_pkg::rsp_t      rsp
);
  import mi_pkg::*;

  logic core_idle;
  logic core_done;
  logic core_take;
  logic start;
  rsp_t core_rsp;

  assign req_stall = !core_idle;
  assign start     = req_valid && core_idle;
  assign core_take = core_done && (!rsp_valid || !rsp_stall);

  mi_euclid u_euclid (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .take (core_take),
    .idle (core_idle),
    .done (core_done),
    .rsp  (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (core_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      rsp <= core_rsp;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/modular_inverse_tb.sv @@
// Self-checking testbench for modular_inverse: directed and random requests,
// each response compared with a modular inverse computed by extended Euclid.
// Depends on mi_pkg and the modular_inverse RTL.
`timescale 1ns / 1ps

module modular_inverse_tb;

  import mi_pkg::*;

  localparam int NUM_RANDOM   = 1330;
  localparam int QUIET_TAIL   = 150;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    req_t req;
    bit   drain;
  } pending_t;

  typedef struct packed {
    req_t req;
    rsp_t rsp;
  } expected_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  pending_t  pending_reqs[$];
  expected_t expected_rsps[$];

  int send_gap = 0;
  int stall_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int num_ok = 0;
  int num_noinv = 0;
  int num_badmod = 0;
  int num_checked = 0;

  modular_inverse dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  function automatic rsp_t predict_inverse(logic [WIDTH-1:0] a, logic [WIDTH-1:0] m);
    logic [63:0] r_prev, r_cur, u_prev, u_cur, q, r_next, u_next, m64;
    bit          cur_pos;
    rsp_t        res;
    res.inverse = '0;
    res.status  = STAT_OK;
    m64 = 64'(m);
    if (m == '0) begin
      res.status = STAT_BADMOD;
      return res;
    end
    if (m64 == 64'd1) begin
      return res;
    end
    r_prev  = m64;
    r_cur   = 64'(a) % m64;
    u_prev  = 64'd0;
    u_cur   = 64'd1;
    cur_pos = 1'b1;
    while (r_cur != 64'd0) begin
      q       = r_prev / r_cur;
      r_next  = r_prev - q * r_cur;
      u_next  = u_prev + q * u_cur;
      r_prev  = r_cur;
      r_cur   = r_next;
      u_prev  = u_cur;
      u_cur   = u_next;
      cur_pos = ~cur_pos;
    end
    if (r_prev != 64'd1) begin
      res.status = STAT_NOINV;
      return res;
    end
    u_prev = u_prev % m64;
    if (!cur_pos) begin
      res.inverse = u_prev[WIDTH-1:0];
    end else begin
      res.inverse = (u_prev == 64'd0) ? '0 : WIDTH'(m64 - u_prev);
    end
    return res;
  endfunction

  task automatic add_request(logic [WIDTH-1:0] value, logic [WIDTH-1:0] modulus, bit drain);
    pending_t p;
    p.req.value   = value;
    p.req.modulus = modulus;
    p.drain       = drain;
    pending_reqs.push_back(p);
  endtask

  task automatic add_random_request(bit drain);
    logic [WIDTH-1:0] value, modulus, factor;
    int               kind;
    kind    = $urandom_range(0, 19);
    value   = $urandom;
    modulus = $urandom;
    case (kind)
      3, 4: begin
        modulus = $urandom_range(1, 1000);
      end
      5: begin
        factor  = $urandom_range(2, 50);
        modulus = factor * $urandom_range(1, 80000000);
        value   = factor * $urandom_range(0, 80000000);
      end
      6: begin
        modulus = $urandom_range(1, 100000);
        value   = modulus * $urandom_range(0, 40000);
      end
      7, 8: begin
        modulus = $urandom | 32'd1;
      end
      9: begin
        value = $urandom_range(0, 1) ? '0 : value;
        modulus = $urandom_range(0, 1);
      end
      10, 11: begin
        modulus = modulus | 32'd2;
        value   = value % modulus;
      end
      12: begin
        modulus = 32'hFFFF_FFFF - $urandom_range(0, 100);
      end
      13: begin
        modulus = 32'd1 << $urandom_range(1, 31);
      end
      14: begin
        value = 32'hFFFF_FFFF - $urandom_range(0, 100);
      end
      default: begin
      end
    endcase
    add_request(value, modulus, drain);
  endtask

  // Request driver: presents the next pending request, with random idle bursts.
  always @(posedge clk) begin
    logic     nvalid;
    req_t     npay;
    pending_t p;
    nvalid = req_valid;
    npay   = req;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back({req, predict_inverse(req.value, req.modulus)});
        nvalid = 1'b0;
        if ((pending_reqs.size() >= QUIET_TAIL) && ($urandom_range(0, 3) == 0)) begin
          send_gap = $urandom_range(1, 17);
        end
      end
      if (!nvalid) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          if (!(pending_reqs[0].drain && expected_rsps.size() > 0)) begin
            p      = pending_reqs.pop_front();
            npay   = p.req;
            nvalid = 1'b1;
          end
        end
      end
    end
    req_valid <= nvalid;
    req       <= npay;
  end

  // Response monitor: checks each accepted response and drives random stalls.
  always @(posedge clk) begin
    logic      nstall;
    expected_t exp_item;
    nstall = 1'b0;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS) begin
            $display("Unexpected response: inverse=%0d status=%0d", rsp.inverse, rsp.status);
          end
        end else begin
          exp_item    = expected_rsps.pop_front();
          num_checked = num_checked + 1;
          case (exp_item.rsp.status)
            STAT_OK:     num_ok = num_ok + 1;
            STAT_NOINV:  num_noinv = num_noinv + 1;
            default:     num_badmod = num_badmod + 1;
          endcase
          if (rsp.inverse !== exp_item.rsp.inverse || rsp.status !== exp_item.rsp.status) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS) begin
              $display({"Mismatch for value=%0d modulus=%0d: ",
                        "expected inverse=%0d status=%0d, got inverse=%0d status=%0d"},
                       exp_item.req.value, exp_item.req.modulus, exp_item.rsp.inverse,
                       exp_item.rsp.status, rsp.inverse, rsp.status);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        nstall     = 1'b1;
      end else if ((pending_reqs.size() >= QUIET_TAIL) && ($urandom_range(0, 7) == 0)) begin
        stall_left = $urandom_range(0, 16);
        nstall     = 1'b1;
      end
    end
    rsp_stall <= nstall;
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or response accepted for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Directed part: invalid and unit moduli, zero and reduced values,
    // shared factors, extreme operands and a worst-case Fibonacci pair.
    add_request(32'd0, 32'd0, 1'b0);
    add_request(32'hFFFF_FFFF, 32'd0, 1'b0);
    add_request(32'd0, 32'd1, 1'b0);
    add_request(32'hFFFF_FFFF, 32'd1, 1'b0);
    add_request(32'd0, 32'd7, 1'b0);
    add_request(32'd1, 32'd7, 1'b0);
    add_request(32'd3, 32'd7, 1'b0);
    add_request(32'd7, 32'd7, 1'b0);
    add_request(32'd100, 32'd7, 1'b0);
    add_request(32'd6, 32'd9, 1'b0);
    add_request(32'd1, 32'd2, 1'b0);
    add_request(32'd2, 32'd2, 1'b0);
    add_request(32'd2, 32'h7FFF_FFFF, 1'b0);
    add_request(32'd2, 32'hFFFF_FFFF, 1'b0);
    add_request(32'd3, 32'hFFFF_FFFF, 1'b0);
    add_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_request(32'd1836311903, 32'd2971215073, 1'b0);
    add_request(32'd2971215073, 32'd1836311903, 1'b0);
    add_request(32'h8000_0000, 32'h8000_0001, 1'b0);
    add_request(32'd4, 32'h8000_0000, 1'b0);
    add_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      add_random_request((i % 300) == 0);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || req_valid) @(posedge clk);
    while (expected_rsps.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses: %0d with an inverse, %0d without, %0d with a zero modulus.",
             num_checked, num_ok, num_noinv, num_badmod);
    $display("Mismatches or unexpected responses: %0d.", mismatches);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mi_pkg.sv
src/mi_euclid.sv
src/modular_inverse.sv
tb/sv/modular_inverse_tb.sv
